[rtl/aes_pkg.sv]
// Shared types, constants and GF(2^8) helpers for the AES-256 block cipher.
// No dependencies; every other file uses this package by scoped names.
`default_nettype none
package aes_pkg;

  localparam int unsigned Rounds   = 14;
  localparam int unsigned KeyWords = 60;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned RoundW   = 4;

  typedef enum logic [0:0] {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_e;

  localparam logic [CfgIdxW-1:0] REG_KEY0 = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1 = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3 = 2'd3;

  localparam logic [7:0] RconInit = 8'h01;

  // Round key selection between the key store and the round datapath.
  typedef struct packed {
    logic              dec;
    logic [RoundW-1:0] round;
  } rk_req_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    mix_col = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
               xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    a[0] = w[31:24]; a[1] = w[23:16]; a[2] = w[15:8]; a[3] = w[7:0];
    for (int i = 0; i < 4; i++) begin
      x2[i] = xt(a[i]);
      x4[i] = xt(x2[i]);
      x8[i] = xt(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                   m9[0] ^ me[1] ^ mb[2] ^ md[3],
                   md[0] ^ m9[1] ^ me[2] ^ mb[3],
                   mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage
`default_nettype wire

[rtl/aes_key_sched.sv]
// Key store and schedule: holds the key registers and steps a key expansion
// of one word per cycle into 15-row encryption and decryption key stores. Uses aes_pkg.
`default_nettype none
module aes_key_sched (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [63:0]           cfg_wdata_i,
  input  wire aes_pkg::rk_req_t      rk_req_i,
  output logic [127:0]               rk_o,
  output logic                       busy_o
);

  logic [63:0]  key_q [4];
  logic [127:0] ek_q [15];
  logic [127:0] dk_q [15];
  logic [31:0]  win_q [8];
  logic [5:0]   idx_q, idx_d;
  logic [7:0]   rc_q, rc_d;
  logic         busy_q, busy_d;
  logic [31:0]  w_new;
  logic [31:0]  t;
  logic [6:0]   col_lsb;
  logic [3:0]   dk_row;

  // Expansion word i; words 0..7 come straight from the key. The window holds
  // the last eight words, oldest (i-8) at index 0 and newest (i-1) at index 7.
  always_comb begin
    t = win_q[7];
    if (idx_q[2:0] == 3'd0) begin
      t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
    end else if (idx_q[2:0] == 3'd4) begin
      t = aes_pkg::sub_word(t);
    end
    w_new = win_q[0] ^ t;
    if (idx_q < 6'd8) begin
      w_new = idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32];
    end
  end

  always_comb begin
    idx_d  = idx_q;
    rc_d   = rc_q;
    busy_d = busy_q;
    if (cfg_we_i) begin
      idx_d  = '0;
      rc_d   = aes_pkg::RconInit;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (idx_q[2:0] == 3'd0 && idx_q >= 6'd8) rc_d = aes_pkg::xt(rc_q);
      if (idx_q == 6'(aes_pkg::KeyWords - 1)) busy_d = 1'b0;
      else idx_d = idx_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      rc_q   <= aes_pkg::RconInit;
      busy_q <= 1'b1;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else begin
      idx_q  <= idx_d;
      rc_q   <= rc_d;
      busy_q <= busy_d;
      if (cfg_we_i) key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Word i lands in row i/4, column i%4; the decryption copy goes to row 14 - i/4.
  assign col_lsb = {2'd3 - idx_q[1:0], 5'd0};
  assign dk_row  = 4'd14 - idx_q[5:2];

  always_ff @(posedge clk_i) begin
    if (busy_q && !cfg_we_i) begin
      for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
      win_q[7] <= w_new;
      ek_q[idx_q[5:2]][col_lsb +: 32] <= w_new;
      if (idx_q < 6'd4 || idx_q >= 6'd56) begin
        dk_q[dk_row][col_lsb +: 32] <= w_new;
      end else begin
        dk_q[dk_row][col_lsb +: 32] <= aes_pkg::inv_mix_col(w_new);
      end
    end
  end

  always_comb begin
    if (rk_req_i.dec) begin
      rk_o = dk_q[rk_req_i.round];
    end else begin
      rk_o = ek_q[rk_req_i.round];
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

[rtl/aes_round.sv]
// One shared AES round datapath (forward or equivalent inverse), used once per
// cycle by the top-level sequencer. Uses aes_pkg.
`default_nettype none
module aes_round (
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] rk_i,
  input  wire logic         dec_i,
  input  wire logic         last_i,
  output logic [127:0]      state_o
);

  logic [7:0]  s [16];
  logic [7:0]  t [16];
  logic [31:0] col [4];

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = state_i[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec_i) t[4*((c + r) % 4) + r] = aes_pkg::inv_sbox(s[4*c + r]);
        else       t[4*c + r] = aes_pkg::sbox(s[4*((c + r) % 4) + r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      col[c] = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
      if (!last_i) begin
        col[c] = dec_i ? aes_pkg::inv_mix_col(col[c]) : aes_pkg::mix_col(col[c]);
      end
    end
    state_o = {col[0], col[1], col[2], col[3]} ^ rk_i;
  end

endmodule
`default_nettype wire

[rtl/aes256_block_cipher_top.sv]
// AES-256 block cipher top level: sequencer, state register and output beat.
// Uses aes_pkg, aes_key_sched and aes_round.
// The key add is done at the input beat, then the 14 rounds run on the shared round
// unit, one per cycle, before the output beat is offered. A new input beat is taken
// only after the previous output beat has been taken.
// After reset or any key write the schedule expands all 60 key words, one per cycle,
// and no input beat is taken meanwhile.
`default_nettype none
module aes256_block_cipher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [63:0] block_upper_i,
  input  wire logic [63:0] block_lower_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_upper_o,
  output logic [63:0]      out_lower_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e               st_q, st_d;
  logic [3:0]           rnd_q, rnd_d;
  logic                 dec_q;
  logic [127:0]         data_q;
  logic [127:0]         rnd_out;
  logic [127:0]         rk;
  logic                 ks_busy;
  aes_pkg::rk_req_t     rk_req;
  logic                 in_fire;
  logic                 cfg_ok;

  assign cfg_ok     = cfg_we_i;
  assign in_ready_o = (st_q == ST_IDLE) && !ks_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    rk_req.dec   = in_fire ? cmd_i : dec_q;
    rk_req.round = in_fire ? 4'd0 : rnd_q;
  end

  aes_key_sched u_ks (
    .clk_i, .rst_ni,
    .cfg_we_i (cfg_ok), .cfg_idx_i, .cfg_wdata_i,
    .rk_req_i (rk_req), .rk_o (rk), .busy_o (ks_busy)
  );

  aes_round u_round (
    .state_i (data_q), .rk_i (rk), .dec_i (dec_q),
    .last_i  (rnd_q == 4'(aes_pkg::Rounds)), .state_o (rnd_out)
  );

  always_comb begin
    st_d  = st_q;
    rnd_d = rnd_q;
    unique case (st_q)
      ST_IDLE: if (in_fire) begin st_d = ST_RUN; rnd_d = 4'd1; end
      ST_RUN: begin
        if (rnd_q == 4'(aes_pkg::Rounds)) st_d = ST_OUT;
        else rnd_d = rnd_q + 4'd1;
      end
      ST_OUT: if (out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      rnd_q <= '0;
    end else begin
      st_q  <= st_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dec_q  <= cmd_i;
      data_q <= {block_upper_i, block_lower_i} ^ rk;
    end else if (st_q == ST_RUN) begin
      data_q <= rnd_out;
    end
  end

  assign out_valid_o = (st_q == ST_OUT);
  assign out_upper_o = data_q[127:64];
  assign out_lower_o = data_q[63:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_q))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ks_busy |-> !in_ready_o)
    else $error("input taken during key expansion");
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> st_q == ST_RUN && rnd_q == 4'd1)
    else $error("round sequence did not start");

endmodule
`default_nettype wire

[verif/aes256_block_cipher_top_tb.sv]
// Testbench for aes256_block_cipher_top: random and known blocks, both directions.
// Keeps its own AES-256 predictor and key schedule; uses types and constants from aes_pkg only.
`timescale 1ns / 100ps
module aes256_block_cipher_top_tb;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned DrainWait  = 80;
  localparam logic [7:0]  RconFirst  = 8'h01;
  localparam logic [7:0]  SboxAffine = 8'h63;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = aes_pkg::REG_KEY0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = aes_pkg::CMD_ENC;
  logic [63:0] block_upper_i = '0;
  logic [63:0] block_lower_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] out_upper_o;
  logic [63:0] out_lower_o;

  aes256_block_cipher_top dut (.*);

  always #1 clk_i = ~clk_i;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
  } block_t;

  logic [7:0]  fwd_sub [256];
  logic [7:0]  inv_sub [256];
  logic [63:0] key_word [4];
  logic [31:0] enc_rk [60];
  logic [31:0] dec_rk [60];
  block_t      pending_blocks [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          gaps_on = 1'b1;
  logic [1:0]  key_idx [4] = '{aes_pkg::REG_KEY0, aes_pkg::REG_KEY1,
                               aes_pkg::REG_KEY2, aes_pkg::REG_KEY3};

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = xtime(a);
    end
    return r;
  endfunction

  // Build the S-boxes from the field inverse and the affine map.
  task automatic build_sboxes();
    logic [7:0] inv, s;
    for (int b = 0; b < 256; b++) begin
      inv = '0;
      for (int y = 1; y < 256; y++)
        if (gf_mul(8'(b), 8'(y)) == 8'h01) inv = 8'(y);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ SboxAffine;
      fwd_sub[b] = s;
      inv_sub[s] = 8'(b);
    end
  endtask

  function automatic logic [31:0] col_mul(logic [31:0] w, bit inverse);
    logic [7:0] a [4];
    logic [7:0] m [4];
    logic [31:0] r;
    for (int i = 0; i < 4; i++) a[i] = w[31-8*i -: 8];
    if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else         m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int row = 0; row < 4; row++) begin
      r[31-8*row -: 8] = '0;
      for (int i = 0; i < 4; i++)
        r[31-8*row -: 8] ^= gf_mul(a[i], m[(i - row + 4) % 4]);
    end
    return r;
  endfunction

  function automatic logic [31:0] sub_bytes_word(logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  task automatic expand_key();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = RconFirst;
    for (int i = 0; i < 4; i++) begin
      enc_rk[2*i]   = key_word[i][63:32];
      enc_rk[2*i+1] = key_word[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = enc_rk[i-1];
      if (i % 8 == 0) begin
        t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xtime(rc);
      end else if (i % 8 == 4) begin
        t = sub_bytes_word(t);
      end
      enc_rk[i] = enc_rk[i-8] ^ t;
    end
    for (int j = 0; j < 4; j++) begin
      dec_rk[j]      = enc_rk[56 + j];
      dec_rk[56 + j] = enc_rk[j];
    end
    for (int r = 1; r < 14; r++)
      for (int j = 0; j < 4; j++)
        dec_rk[4*r + j] = col_mul(enc_rk[4*(14 - r) + j], 1'b1);
  endtask

  function automatic block_t cipher_block(bit dec, block_t blk);
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [31:0] k [60];
    logic [31:0] col;
    logic [127:0] flat;
    block_t res;
    if (dec) k = dec_rk;
    else     k = enc_rk;
    flat = blk;
    for (int i = 0; i < 16; i++) s[i] = flat[127-8*i -: 8];
    for (int r = 0; r <= 14; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++)
            if (dec) t[4*((c + w) % 4) + w] = inv_sub[s[4*c + w]];
            else     t[4*c + w] = fwd_sub[s[4*((c + w) % 4) + w]];
        s = t;
        if (r < 14)
          for (int c = 0; c < 4; c++) begin
            col = col_mul({s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]}, dec);
            for (int w = 0; w < 4; w++) s[4*c + w] = col[31-8*w -: 8];
          end
      end
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) s[4*c + w] ^= k[4*r + c][31-8*w -: 8];
    end
    for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = s[i];
    res = flat;
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("aes256_block_cipher_top verification failed");
      $finish;
    end
  end

  // Result checker: compare each output beat with the oldest expected block.
  always @(posedge clk_i) begin
    block_t exp_blk;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h %h", out_upper_o, out_lower_o);
      end else begin
        exp_blk = pending_blocks.pop_front();
        if (out_upper_o !== exp_blk.upper || out_lower_o !== exp_blk.lower) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h, got %h %h",
                     exp_blk.upper, exp_blk.lower, out_upper_o, out_lower_o);
        end
      end
    end
  end

  // Receiver: random stalls and long holds, a long hold on request, or always ready with gaps off.
  always @(posedge clk_i) begin
    int unsigned p;
    p = $urandom_range(99);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!gaps_on) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= (p < 70) ? 1'b1 : 1'b0;
      if (p >= 97) hold_left <= $urandom_range(40, 10);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (!gaps_on || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned p;
    p = $urandom_range(19);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Offer one block; hold valid and payload until the beat is taken.
  task automatic send_block(aes_pkg::cmd_e cmd, logic [63:0] upper, logic [63:0] lower);
    int unsigned gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    block_upper_i <= upper;
    block_lower_i <= lower;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    pending_blocks.push_back(cipher_block(cmd == aes_pkg::CMD_DEC, {upper, lower}));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_key_reg(int unsigned i, logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= key_idx[i];
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_word[i] = value;
    expand_key();
  endtask

  // The write enable drops between writes, which keeps each write enable edge separate.
  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    drain();
    write_key_reg(0, k0);
    @(posedge clk_i);
    write_key_reg(1, k1);
    @(posedge clk_i);
    write_key_reg(2, k2);
    @(posedge clk_i);
    write_key_reg(3, k3);
  endtask

  task automatic test_directed();
    block_t ct;
    // Zero key from reset
    send_block(aes_pkg::CMD_ENC, '0, '0);
    send_block(aes_pkg::CMD_DEC, '0, '0);
    send_block(aes_pkg::CMD_ENC, '1, '1);
    send_block(aes_pkg::CMD_DEC, '1, '1);
    // Known standard vector
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(aes_pkg::CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(aes_pkg::CMD_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    load_key('1, '1, '1, '1);
    send_block(aes_pkg::CMD_ENC, '0, '1);
    send_block(aes_pkg::CMD_DEC, '1, '0);
    // Partly written key is used as it stands
    drain();
    write_key_reg(0, 64'h0123456789abcdef);
    send_block(aes_pkg::CMD_ENC, 64'h8000000000000000, 64'h0000000000000001);
    send_block(aes_pkg::CMD_DEC, 64'h8000000000000000, 64'h0000000000000001);
    drain();
    write_key_reg(3, 64'h0);
    ct = cipher_block(1'b0, {64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555});
    send_block(aes_pkg::CMD_ENC, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555);
    send_block(aes_pkg::CMD_DEC, ct.upper, ct.lower);
  endtask

  task automatic test_random_phase(int unsigned n, bit full_key);
    block_t ct;
    logic [63:0] u, l;
    if (full_key) begin
      load_key(rand_word(), rand_word(), rand_word(), rand_word());
    end else begin
      drain();
      write_key_reg($urandom_range(3), rand_word());
    end
    for (int i = 0; i < n; i++) begin
      u = rand_word();
      l = rand_word();
      if ($urandom_range(3) == 0) begin
        // Round trip: decrypt what was just encrypted
        ct = cipher_block(1'b0, {u, l});
        send_block(aes_pkg::CMD_ENC, u, l);
        send_block(aes_pkg::CMD_DEC, ct.upper, ct.lower);
        i++;
      end else begin
        send_block($urandom_range(1) ? aes_pkg::CMD_DEC : aes_pkg::CMD_ENC, u, l);
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    @(negedge clk_i);
    hold_left = HoldLen;
    @(posedge clk_i);
    for (int i = 0; i < 40; i++)
      send_block($urandom_range(1) ? aes_pkg::CMD_DEC : aes_pkg::CMD_ENC,
                 rand_word(), rand_word());
  endtask

  task automatic test_no_gaps();
    drain();
    gaps_on = 1'b0;
    for (int i = 0; i < 60; i++)
      send_block($urandom_range(1) ? aes_pkg::CMD_DEC : aes_pkg::CMD_ENC,
                 rand_word(), rand_word());
    drain();
    gaps_on = 1'b1;
  endtask

  initial begin
    build_sboxes();
    for (int i = 0; i < 4; i++) key_word[i] = '0;
    expand_key();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int p = 0; p < 5; p++) test_random_phase(180, p != 2);
    test_backpressure();
    test_no_gaps();
    test_random_phase(60, 1'b1);
    drain();
    if (mismatches == 0 && pending_blocks.size() == 0)
      $display("aes256_block_cipher_top verification clean");
    else
      $display("aes256_block_cipher_top verification failed");
    $finish;
  end

endmodule
